// ----- sv/f32add_pkg.sv -----
// Shared types and constants for the single-precision adder.
package f32add_pkg;

    localparam logic [31:0] SIGN_BIT    = 32'h8000_0000;
    localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
    localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
    localparam logic [7:0]  EXP_MAX     = 8'hFF;

    // Aligned operands, stage 1 to stage 2.
    typedef struct packed {
        logic        special;
        logic [31:0] special_val;
        logic        sx;
        logic        sub;
        logic        both_neg;
        logic [7:0]  ex;
        logic [26:0] mx;
        logic [26:0] my;
    } align_t;

    // Raw sum, stage 2 to stage 3.
    typedef struct packed {
        logic        special;
        logic [31:0] special_val;
        logic        sx;
        logic        both_neg;
        logic [7:0]  ex;
        logic [27:0] m;
    } sum_t;

    // Normalized sum, stage 3 to stage 4.
    typedef struct packed {
        logic        special;
        logic [31:0] special_val;
        logic        zero;
        logic        both_neg;
        logic        sx;
        logic [8:0]  e;
        logic [26:0] m;
    } norm_t;

endpackage

// ----- sv/f32add_stream_if.sv -----
// Valid/ready channel carrying one payload per beat.
interface f32add_stream_if #(
    parameter int WIDTH = 32
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- sv/f32add_align.sv -----
// Stage 1 logic: special cases, operand swap and exponent alignment.
module f32add_align (
    input  logic [31:0]          a,
    input  logic [31:0]          b,
    output f32add_pkg::align_t   info
);
    logic        a_nan, b_nan, a_inf, b_inf;
    logic [31:0] x, y;
    logic [7:0]  ex, ey, d;
    logic [26:0] mx, my, my_sh, lost_mask;

    always_comb
    begin
        a_nan = (a[30:23] == f32add_pkg::EXP_MAX) && (a[22:0] != '0);
        b_nan = (b[30:23] == f32add_pkg::EXP_MAX) && (b[22:0] != '0);
        a_inf = (a[30:23] == f32add_pkg::EXP_MAX) && (a[22:0] == '0);
        b_inf = (b[30:23] == f32add_pkg::EXP_MAX) && (b[22:0] == '0);

        // Larger magnitude goes to x.
        if (a[30:0] >= b[30:0])
        begin
            x = a;
            y = b;
        end
        else
        begin
            x = b;
            y = a;
        end

        ex = (x[30:23] != '0) ? x[30:23] : 8'd1;
        ey = (y[30:23] != '0) ? y[30:23] : 8'd1;
        mx = {(x[30:23] != '0), x[22:0], 3'b000};
        my = {(y[30:23] != '0), y[22:0], 3'b000};
        d  = ex - ey;

        // Shift right with a sticky bit for everything shifted out.
        lost_mask = '0;
        if (d > 8'd30)
        begin
            my_sh = {26'd0, (my != '0)};
        end
        else
        begin
            lost_mask = ~(27'h7FF_FFFF << d[4:0]);
            my_sh     = (my >> d[4:0]) | {26'd0, ((my & lost_mask) != '0)};
        end

        info.sx       = x[31];
        info.sub      = x[31] ^ y[31];
        info.both_neg = x[31] & y[31];
        info.ex       = ex;
        info.mx       = mx;
        info.my       = my_sh;

        info.special     = 1'b1;
        info.special_val = a;
        priority if (b_nan)
            info.special_val = b | f32add_pkg::QUIET_BIT;
        else if (a_nan)
            info.special_val = a | f32add_pkg::QUIET_BIT;
        else if (a_inf && b_inf && (a[31] != b[31]))
            info.special_val = f32add_pkg::DEFAULT_NAN;
        else if (b_inf)
            info.special_val = b;
        else if (a_inf)
            info.special_val = a;
        else
            info.special = 1'b0;
    end
endmodule

// ----- sv/f32add_norm.sv -----
// Stage 3 logic: one-bit right normalize or leading-zero left shift.
module f32add_norm (
    input  f32add_pkg::sum_t  s,
    output f32add_pkg::norm_t n
);
    logic [4:0]  lz;
    logic [4:0]  sh;
    logic [7:0]  room;

    always_comb
    begin
        // Leading zeros above bit 26 (m below 2^27 here).
        lz = 5'd27;
        for (int i = 0; i <= 26; i++)
        begin
            if (s.m[i])
                lz = 5'(26 - i);
        end
        room = s.ex - 8'd1;
        sh   = ({3'd0, lz} > room) ? room[4:0] : lz;

        n.special     = s.special;
        n.special_val = s.special_val;
        n.zero        = (s.m == '0);
        n.both_neg    = s.both_neg;
        n.sx          = s.sx;
        if (s.m[27])
        begin
            n.m = s.m[27:1] | {26'd0, s.m[0]};
            n.e = {1'b0, s.ex} + 9'd1;
        end
        else
        begin
            n.m = s.m[26:0] << sh;
            n.e = {1'b0, s.ex} - {4'd0, sh};
        end
    end
endmodule

// ----- sv/f32add_round.sv -----
// Stage 4 logic: round to nearest even and pack the result.
module f32add_round (
    input  f32add_pkg::norm_t n,
    output logic [31:0]       sum
);
    logic [24:0] r;
    logic [8:0]  e;
    logic [23:0] m;
    logic        up;

    always_comb
    begin
        up = (n.m[2:0] > 3'd4) || ((n.m[2:0] == 3'd4) && n.m[3]);
        r  = {1'b0, n.m[26:3]} + {24'd0, up};
        e  = n.e;
        m  = r[23:0];
        if (r[24])
        begin
            m = r[24:1];
            e = n.e + 9'd1;
        end

        if (n.special)
            sum = n.special_val;
        else if (n.zero)
            sum = n.both_neg ? f32add_pkg::SIGN_BIT : 32'd0;
        else if (e >= {1'b0, f32add_pkg::EXP_MAX})
            sum = {n.sx, f32add_pkg::EXP_MAX, 23'd0};
        else
            sum = {n.sx, (m[23] ? e[7:0] : 8'd0), m[22:0]};
    end
endmodule

// ----- sv/float32_adder_core.sv -----
// Top level of the pipelined single-precision adder.
// Four register stages: align, add, normalize, round. One operand pair can
// enter every cycle while the pipe advances; its sum passes through the
// s1, s2, s3 and s4 registers to the output. The whole pipe advances together
// whenever the output register is empty or being taken, so it holds as a unit
// when the output beat is not taken. Rounding is to nearest even only.
module float32_adder_core (
    input  logic                   clk,
    input  logic                   rst_n,
    f32add_stream_if.sink          in_ch,
    f32add_stream_if.source        out_ch
);
    logic                 v1_reg, v2_reg, v3_reg, v4_reg;
    f32add_pkg::align_t   s1_reg, s1_next;
    f32add_pkg::sum_t     s2_reg, s2_next;
    f32add_pkg::norm_t    s3_reg, s3_next;
    logic [31:0]          s4_reg, s4_next;
    logic                 adv;

    // Pipe moves when the last stage is empty or being taken.
    assign adv          = !v4_reg || out_ch.ready;
    assign in_ch.ready  = adv;
    assign out_ch.valid = v4_reg;
    assign out_ch.data  = s4_reg;

    f32add_align u_align (
        .a    (in_ch.data[31:0]),
        .b    (in_ch.data[63:32]),
        .info (s1_next)
    );

    // Add or subtract the aligned significands.
    always_comb
    begin
        s2_next.special     = s1_reg.special;
        s2_next.special_val = s1_reg.special_val;
        s2_next.sx          = s1_reg.sx;
        s2_next.both_neg    = s1_reg.both_neg;
        s2_next.ex          = s1_reg.ex;
        s2_next.m           = s1_reg.sub ? ({1'b0, s1_reg.mx} - {1'b0, s1_reg.my})
                                         : ({1'b0, s1_reg.mx} + {1'b0, s1_reg.my});
    end

    f32add_norm u_norm (
        .s (s2_reg),
        .n (s3_next)
    );

    f32add_round u_round (
        .n   (s3_reg),
        .sum (s4_next)
    );

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_ch.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
        end
    end

`ifndef ASSERT_OFF
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.data)))
        else $error("output beat changed while stalled");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && v3_reg) |=> v4_reg)
        else $error("item lost between normalize and round");
    a_norm: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !s3_reg.special && !s3_reg.zero && s3_reg.e > 9'd1) |-> s3_reg.m[26])
        else $error("normalized significand lacks leading one");
`endif
endmodule
